// File: design/sle_pkg.sv
package sle_pkg;

	// Operation codes carried on the op field.
	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_DELETE = 2'd1;
	localparam logic [1:0] OP_READ   = 2'd2;

	// Status codes carried on the status field.
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_FULL    = 2'd1;
	localparam logic [1:0] ST_BAD_POS = 2'd2;
	localparam logic [1:0] ST_EMPTY   = 2'd3;

	typedef enum logic [3:0] {
		S_IDLE,
		S_INS_SHIFT,
		S_INS_DRAIN,
		S_INS_PUT,
		S_DEL_SCAN,
		S_DEL_DRAIN,
		S_RD_ISSUE,
		S_RESP
	} state_t;

endpackage

// File: design/sequential_list_engine.sv
// Ordered list engine: an array list of signed 32-bit entries with 1-based positions.
// The request channel (in_valid, in_ready, op, position, value) carries one insert,
// delete-all-equal or read request. The result channel (out_valid, out_ready, status,
// read_value, list_length) returns exactly one result per request, in request order.
// The block works on one request at a time: in_ready is high while no request is in
// work, including while a finished result still waits in the output register.
// Each request is worked in steps: a read at a valid position issues one entry
// read and then loads the result; a refused request or an unused op code goes
// straight to loading the result; an insert at position p into n entries shifts
// entries p to n up one slot, last entry first, then writes the value at p, or
// writes it directly when p = n + 1; a delete on n entries scans all n entries.
// The entry memory has one read and one write port: insert moves one entry and
// delete examines one entry per cycle, each a read followed in the next cycle by
// a write. The next request is accepted in the cycle after the result is loaded.
// Reset clears the entry count and all handshake state; the entry memory itself is
// not cleared, since only entries below the count are ever read.
// When the receiver stalls, the result holds in the output register; a following
// request is still accepted and worked, and its result waits until the register frees.
module sequential_list_engine #(
	parameter int CAPACITY = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  op,
	input  logic [7:0]  position,
	input  logic signed [31:0] value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic signed [31:0] read_value,
	output logic [7:0]  list_length
);
	import sle_pkg::*;

	// Address width, count width, and a comparison width that holds both a count
	// and an 8-bit position plus one.
	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int PW = ((CW > 8) ? CW : 8) + 1;

	state_t state_q, state_d;

	logic [CW-1:0] count_q;
	logic [AW-1:0] ptr_q;
	logic [AW-1:0] pos_idx_q;
	logic [CW-1:0] wr_q;
	logic [31:0]   val_q;
	logic [1:0]    status_q;
	logic          rv_use_q;

	// Entry memory with a registered read port.
	logic [31:0]   entry_mem [CAPACITY];
	logic          mem_rd_en;
	logic [AW-1:0] mem_rd_addr;
	logic          mem_wr_en;
	logic [AW-1:0] mem_wr_addr;
	logic [31:0]   mem_wr_data;
	logic [31:0]   mem_rd_data_s1;
	logic [AW-1:0] mem_rd_addr_s1;
	logic          mem_rd_vld_s1;

	logic          out_vld_q;
	logic          accept;
	logic          resp_load;
	logic          ins_last;
	logic          del_last;
	logic          del_keep;

	logic [PW-1:0] pos_w;
	logic [PW-1:0] cnt_w;
	logic [1:0]    acc_status;
	state_t        acc_next;

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign resp_load = (state_q == S_RESP) && (!out_vld_q || out_ready);
	assign out_valid = out_vld_q;

	assign pos_w = PW'(position);
	assign cnt_w = PW'(count_q);

	// The insert shift walks down from the last entry to the insert position;
	// the delete scan walks up from the first entry to the last.
	assign ins_last = (ptr_q == pos_idx_q);
	assign del_last = ((PW'(ptr_q) + PW'(1)) == cnt_w);
	assign del_keep = (mem_rd_data_s1 != val_q);

	// Decode an arriving request: its status and where the work begins.
	always_comb begin
		acc_status = ST_OK;
		acc_next   = S_RESP;
		case (op)
			OP_INSERT: begin
				if (cnt_w >= PW'(CAPACITY)) begin
					acc_status = ST_FULL;
				end else if (pos_w == '0 || pos_w > cnt_w + PW'(1)) begin
					acc_status = ST_BAD_POS;
				end else if (pos_w == cnt_w + PW'(1)) begin
					acc_next = S_INS_PUT;
				end else begin
					acc_next = S_INS_SHIFT;
				end
			end
			OP_DELETE: begin
				if (count_q == '0) begin
					acc_status = ST_EMPTY;
				end else begin
					acc_next = S_DEL_SCAN;
				end
			end
			OP_READ: begin
				if (pos_w == '0 || pos_w > cnt_w) begin
					acc_status = ST_BAD_POS;
				end else begin
					acc_next = S_RD_ISSUE;
				end
			end
			default: begin
				acc_status = ST_OK;
				acc_next   = S_RESP;
			end
		endcase
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = acc_next;
				end
			end
			S_INS_SHIFT: begin
				if (ins_last) begin
					state_d = S_INS_DRAIN;
				end
			end
			S_INS_DRAIN: state_d = S_INS_PUT;
			S_INS_PUT:   state_d = S_RESP;
			S_DEL_SCAN: begin
				if (del_last) begin
					state_d = S_DEL_DRAIN;
				end
			end
			S_DEL_DRAIN: state_d = S_RESP;
			S_RD_ISSUE:  state_d = S_RESP;
			S_RESP: begin
				if (resp_load) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Memory control. Reads are issued in the walking states and the read-issue state;
	// the write lands in the next cycle, one slot up for insert and at the compaction
	// pointer for delete, so a write never meets the read issued in the same cycle.
	always_comb begin
		mem_rd_en   = 1'b0;
		mem_rd_addr = ptr_q;
		mem_wr_en   = 1'b0;
		mem_wr_addr = AW'(mem_rd_addr_s1 + AW'(1));
		mem_wr_data = mem_rd_data_s1;
		case (state_q)
			S_INS_SHIFT: begin
				mem_rd_en = 1'b1;
				mem_wr_en = mem_rd_vld_s1;
			end
			S_INS_DRAIN: begin
				mem_wr_en = mem_rd_vld_s1;
			end
			S_INS_PUT: begin
				mem_wr_en   = 1'b1;
				mem_wr_addr = pos_idx_q;
				mem_wr_data = val_q;
			end
			S_DEL_SCAN: begin
				mem_rd_en   = 1'b1;
				mem_wr_en   = mem_rd_vld_s1 && del_keep;
				mem_wr_addr = wr_q[AW-1:0];
			end
			S_DEL_DRAIN: begin
				mem_wr_en   = mem_rd_vld_s1 && del_keep;
				mem_wr_addr = wr_q[AW-1:0];
			end
			S_RD_ISSUE: begin
				mem_rd_en   = 1'b1;
				mem_rd_addr = pos_idx_q;
			end
			default: begin
				mem_rd_en = 1'b0;
				mem_wr_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_wr_en) begin
			entry_mem[mem_wr_addr] <= mem_wr_data;
		end
		if (mem_rd_en) begin
			mem_rd_data_s1 <= entry_mem[mem_rd_addr];
			mem_rd_addr_s1 <= mem_rd_addr;
		end
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			count_q       <= '0;
			mem_rd_vld_s1 <= 1'b0;
			out_vld_q     <= 1'b0;
		end else begin
			state_q       <= state_d;
			mem_rd_vld_s1 <= mem_rd_en;
			if (state_q == S_INS_PUT) begin
				count_q <= count_q + CW'(1);
			end else if (state_q == S_DEL_DRAIN) begin
				count_q <= wr_q + CW'(del_keep);
			end
			if (resp_load) begin
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// Request and walk registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			val_q     <= value;
			status_q  <= acc_status;
			rv_use_q  <= (acc_next == S_RD_ISSUE);
			pos_idx_q <= AW'(pos_w - PW'(1));
			wr_q      <= '0;
			if (op == OP_INSERT) begin
				ptr_q <= AW'(cnt_w - PW'(1));
			end else begin
				ptr_q <= '0;
			end
		end else if (state_q == S_INS_SHIFT) begin
			ptr_q <= ptr_q - AW'(1);
		end else if (state_q == S_DEL_SCAN) begin
			ptr_q <= ptr_q + AW'(1);
			if (mem_rd_vld_s1 && del_keep) begin
				wr_q <= wr_q + CW'(1);
			end
		end
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (resp_load) begin
			status      <= status_q;
			read_value  <= rv_use_q ? mem_rd_data_s1 : '0;
			list_length <= cnt_w[7:0];
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		PW'(count_q) <= PW'(CAPACITY))
		else $error("entry count exceeds capacity");

	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_wr_en && mem_rd_en) |-> (mem_wr_addr != mem_rd_addr))
		else $error("write and read hit the same entry in one cycle");

	a_compact_behind: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DEL_SCAN && mem_wr_en) |-> (PW'(wr_q) < PW'(ptr_q)))
		else $error("compaction write overtook the scan");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_INS_PUT) |=> (count_q == $past(count_q) + CW'(1)))
		else $error("insert did not grow the list by one");
`endif

endmodule
